>>> rtl/core/ipsfe_pkg.sv
package ipsfe_pkg;

   // frame geometry
   localparam int FRAME_LEN = 54;
   localparam int IDX_W     = $clog2(FRAME_LEN + 1);
   localparam int ADDR_W    = $clog2(FRAME_LEN);
   localparam int NUM_WORDS = 10;
   localparam int WIDX_W    = $clog2(NUM_WORDS);
   localparam int END_W     = ((IDX_W > 8) ? IDX_W : 8) + 2;

   // header and record codes
   localparam logic [7:0] SYNC_BYTE  = 8'ha5;
   localparam logic [7:0] CLASS_BYTE = 8'ha2;
   localparam logic [7:0] LEN_BYTE   = 8'((FRAME_LEN - 6) & 255);
   localparam logic [7:0] ID_ACCEL   = 8'h81;
   localparam logic [7:0] ID_GYRO    = 8'h82;
   localparam logic [7:0] ID_MAG     = 8'h83;
   localparam logic [7:0] ID_TEMP    = 8'h87;
   localparam logic [7:0] LEN_VEC3   = 8'h0c;
   localparam logic [7:0] LEN_SCALAR = 8'h04;

   // word slots
   localparam logic [WIDX_W-1:0] SLOT_ACCEL = WIDX_W'(0);
   localparam logic [WIDX_W-1:0] SLOT_GYRO  = WIDX_W'(3);
   localparam logic [WIDX_W-1:0] SLOT_MAG   = WIDX_W'(6);
   localparam logic [WIDX_W-1:0] SLOT_TEMP  = WIDX_W'(9);

   typedef enum logic [1:0] {
      PH_HDR,
      PH_SUM,
      PH_WALK
   } phase_type;

   typedef struct packed {
      logic      write;
      logic      start;
      logic      run;
      logic      slide;
      logic      emit;
      phase_type phase;
   } cmd_type;

   typedef struct packed {
      logic last_byte;
      logic done;
      logic hdr_ok;
      logic sum_ok;
      logic out_free;
   } status_type;

endpackage

>>> rtl/core/imu_packet_sync_and_field_extract.sv
// Frame sync for a 54-byte inertial packet (A5 A5 A2 30 header, 8-bit
// Fletcher check bytes at the end). One received byte is taken per beat
// while the block is idle. When the window fills, the header is read back
// from the window memory; a miss slides the window by one byte and nothing
// is returned. A header hit runs the checksum pass and, if good, a second
// pass that walks the descriptor records, then one result beat carries the
// status and the latest ten raw words. Both passes read the window one byte
// per cycle through the single memory read port. The result sits in an
// output register, so further bytes are taken while it waits; a new result
// waits only while the previous one is still held.
module imu_packet_sync_and_field_extract
   import ipsfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_status,
   output logic [31:0] rsp_accel_x_word,
   output logic [31:0] rsp_accel_y_word,
   output logic [31:0] rsp_accel_z_word,
   output logic [31:0] rsp_gyro_x_word,
   output logic [31:0] rsp_gyro_y_word,
   output logic [31:0] rsp_gyro_z_word,
   output logic [31:0] rsp_mag_x_word,
   output logic [31:0] rsp_mag_y_word,
   output logic [31:0] rsp_mag_z_word,
   output logic [31:0] rsp_temp_word
);

   cmd_type     cmd;
   status_type  status;
   logic [31:0] words [NUM_WORDS];

   ipsfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ipsfe_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_rx_byte      (req_rx_byte),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_frame_status (rsp_frame_status),
      .rsp_words        (words)
   );

   assign rsp_accel_x_word = words[0];
   assign rsp_accel_y_word = words[1];
   assign rsp_accel_z_word = words[2];
   assign rsp_gyro_x_word  = words[3];
   assign rsp_gyro_y_word  = words[4];
   assign rsp_gyro_z_word  = words[5];
   assign rsp_mag_x_word   = words[6];
   assign rsp_mag_y_word   = words[7];
   assign rsp_mag_z_word   = words[8];
   assign rsp_temp_word    = words[9];

endmodule

>>> rtl/core/ipsfe_ram.sv
module ipsfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ipsfe_datapath.sv
module ipsfe_datapath
   import ipsfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic        rsp_frame_status,
   output logic [31:0] rsp_words [NUM_WORDS]
);

   typedef enum logic [1:0] {
      W_ID,
      W_LEN,
      W_DATA,
      W_STOP
   } walk_type;

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  rd_off_ff, rd_off_in;
   logic [IDX_W-1:0]  data_off_ff, data_off_in;
   logic              data_vld_ff, data_vld_in;
   logic              hdr_ok_ff, hdr_ok_in;
   logic              sum_ok_ff, sum_ok_in;
   logic [7:0]        s1_ff, s1_in;
   logic [7:0]        s2_ff, s2_in;
   walk_type          walk_ff, walk_in;
   logic [7:0]        id_ff, id_in;
   logic [7:0]        rem_ff, rem_in;
   logic [3:0]        j_ff, j_in;
   logic [23:0]       acc_ff, acc_in;
   logic              cap_ff, cap_in;
   logic [WIDX_W-1:0] slot_ff, slot_in;
   logic [31:0]       words_ff [NUM_WORDS];
   logic              word_we;
   logic [WIDX_W-1:0] word_idx;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff;
   logic [31:0]       rsp_words_ff [NUM_WORDS];

   logic [IDX_W-1:0]  first_off, last_off, ram_off;
   logic [IDX_W:0]    addr_sum, addr_wrap;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        rd_byte, hdr_exp;
   logic              issue;
   logic [END_W-1:0]  rec_end;
   logic [IDX_W:0]    base_next;

   ipsfe_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (ram_waddr),
      .wr_data (req_rx_byte),
      .rd_addr (ram_raddr),
      .rd_data (rd_byte)
   );

   // phase offset range
   always_comb begin
      case (cmd.phase)
         PH_HDR: begin
            first_off = '0;
            last_off  = IDX_W'(4);
         end
         PH_SUM: begin
            first_off = '0;
            last_off  = IDX_W'(FRAME_LEN);
         end
         PH_WALK: begin
            first_off = IDX_W'(4);
            last_off  = IDX_W'(FRAME_LEN - 2);
         end
         default: begin
            first_off = '0;
            last_off  = '0;
         end
      endcase
   end

   // map window offset onto the circular buffer
   assign issue     = cmd.run && (rd_off_ff != last_off);
   assign ram_off   = cmd.write ? fill_ff : rd_off_ff;
   assign addr_sum  = {1'b0, IDX_W'(base_ff)} + {1'b0, ram_off};
   assign addr_wrap = (addr_sum >= (IDX_W + 1)'(FRAME_LEN)) ?
                      addr_sum - (IDX_W + 1)'(FRAME_LEN) : addr_sum;
   assign ram_waddr = addr_wrap[ADDR_W-1:0];
   assign ram_raddr = addr_wrap[ADDR_W-1:0];
   assign base_next = {1'b0, IDX_W'(base_ff)} + (IDX_W + 1)'(1);

   assign rec_end = END_W'(data_off_ff) + END_W'(1) + END_W'(rd_byte);

   always_comb begin
      case (data_off_ff[1:0])
         2'd0:    hdr_exp = SYNC_BYTE;
         2'd1:    hdr_exp = SYNC_BYTE;
         2'd2:    hdr_exp = CLASS_BYTE;
         default: hdr_exp = LEN_BYTE;
      endcase
   end

   // window bookkeeping, read stream and per-phase byte processing
   always_comb begin
      base_in     = base_ff;
      fill_in     = fill_ff;
      rd_off_in   = rd_off_ff;
      data_off_in = rd_off_ff;
      data_vld_in = issue;
      hdr_ok_in   = hdr_ok_ff;
      sum_ok_in   = sum_ok_ff;
      s1_in       = s1_ff;
      s2_in       = s2_ff;
      walk_in     = walk_ff;
      id_in       = id_ff;
      rem_in      = rem_ff;
      j_in        = j_ff;
      acc_in      = acc_ff;
      cap_in      = cap_ff;
      slot_in     = slot_ff;
      word_we     = 1'b0;
      word_idx    = slot_ff + WIDX_W'(j_ff[3:2]);

      if (cmd.write) begin
         fill_in = fill_ff + IDX_W'(1);
      end
      if (cmd.slide) begin
         base_in = (base_next == (IDX_W + 1)'(FRAME_LEN)) ? '0 : base_next[ADDR_W-1:0];
         fill_in = IDX_W'(FRAME_LEN - 1);
      end
      if (cmd.emit) begin
         fill_in = '0;
      end

      if (cmd.start) begin
         rd_off_in   = first_off;
         data_vld_in = 1'b0;
         hdr_ok_in   = 1'b1;
         sum_ok_in   = 1'b1;
         s1_in       = '0;
         s2_in       = '0;
         walk_in     = W_ID;
      end else begin
         if (issue) begin
            rd_off_in = rd_off_ff + IDX_W'(1);
         end
         if (data_vld_ff) begin
            case (cmd.phase)
               PH_HDR: begin
                  if (rd_byte != hdr_exp) begin
                     hdr_ok_in = 1'b0;
                  end
               end
               PH_SUM: begin
                  if (data_off_ff < IDX_W'(FRAME_LEN - 2)) begin
                     s1_in = s1_ff + rd_byte;
                     s2_in = s2_ff + s1_ff + rd_byte;
                  end else if (data_off_ff == IDX_W'(FRAME_LEN - 2)) begin
                     if (rd_byte != s1_ff) begin
                        sum_ok_in = 1'b0;
                     end
                  end else if (rd_byte != s2_ff) begin
                     sum_ok_in = 1'b0;
                  end
               end
               PH_WALK: begin
                  case (walk_ff)
                     W_ID: begin
                        id_in   = rd_byte;
                        walk_in = W_LEN;
                     end
                     W_LEN: begin
                        rem_in = rd_byte;
                        j_in   = '0;
                        cap_in = 1'b0;
                        slot_in = SLOT_TEMP;
                        if (rd_byte == LEN_VEC3) begin
                           if (id_ff == ID_ACCEL) begin
                              cap_in  = 1'b1;
                              slot_in = SLOT_ACCEL;
                           end else if (id_ff == ID_GYRO) begin
                              cap_in  = 1'b1;
                              slot_in = SLOT_GYRO;
                           end else if (id_ff == ID_MAG) begin
                              cap_in  = 1'b1;
                              slot_in = SLOT_MAG;
                           end
                        end else if (rd_byte == LEN_SCALAR && id_ff == ID_TEMP) begin
                           cap_in = 1'b1;
                        end
                        if (rec_end > END_W'(FRAME_LEN - 2)) begin
                           walk_in = W_STOP;
                        end else if (rd_byte == 8'd0) begin
                           walk_in = W_ID;
                        end else begin
                           walk_in = W_DATA;
                        end
                     end
                     W_DATA: begin
                        acc_in = {acc_ff[15:0], rd_byte};
                        j_in   = j_ff + 4'd1;
                        rem_in = rem_ff - 8'd1;
                        if (cap_ff && (j_ff[1:0] == 2'd3)) begin
                           word_we = 1'b1;
                        end
                        if (rem_ff == 8'd1) begin
                           walk_in = W_ID;
                        end
                     end
                     default: begin
                        walk_in = W_STOP;
                     end
                  endcase
               end
               default: begin
                  hdr_ok_in = hdr_ok_ff;
               end
            endcase
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         fill_ff      <= '0;
         rd_off_ff    <= '0;
         data_vld_ff  <= 1'b0;
         walk_ff      <= W_STOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         fill_ff      <= fill_in;
         rd_off_ff    <= rd_off_in;
         data_vld_ff  <= data_vld_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      data_off_ff <= data_off_in;
      hdr_ok_ff   <= hdr_ok_in;
      sum_ok_ff   <= sum_ok_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      id_ff       <= id_in;
      rem_ff      <= rem_in;
      j_ff        <= j_in;
      acc_ff      <= acc_in;
      cap_ff      <= cap_in;
      slot_ff     <= slot_in;
   end

   // latest words, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_WORDS; k++) begin
            words_ff[k] <= '0;
         end
      end else if (word_we) begin
         words_ff[word_idx] <= {acc_ff, rd_byte};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= !sum_ok_ff;
         for (int k = 0; k < NUM_WORDS; k++) begin
            rsp_words_ff[k] <= words_ff[k];
         end
      end
   end

   assign status.last_byte = (fill_ff == IDX_W'(FRAME_LEN - 1));
   assign status.done      = cmd.run && (rd_off_ff == last_off) && !data_vld_ff;
   assign status.hdr_ok    = hdr_ok_ff;
   assign status.sum_ok    = sum_ok_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_words        = rsp_words_ff;

endmodule

>>> rtl/core/ipsfe_ctrl.sv
module ipsfe_ctrl
   import ipsfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR_GO,
      S_HDR_RUN,
      S_SUM_GO,
      S_SUM_RUN,
      S_WALK_GO,
      S_WALK_RUN,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && status.last_byte) begin
               state_in = S_HDR_GO;
            end
         end
         S_HDR_GO:  state_in = S_HDR_RUN;
         S_HDR_RUN: begin
            if (status.done) begin
               state_in = status.hdr_ok ? S_SUM_GO : S_IDLE;
            end
         end
         S_SUM_GO:  state_in = S_SUM_RUN;
         S_SUM_RUN: begin
            if (status.done) begin
               state_in = status.sum_ok ? S_WALK_GO : S_EMIT;
            end
         end
         S_WALK_GO:  state_in = S_WALK_RUN;
         S_WALK_RUN: begin
            if (status.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd.write = accept;
      cmd.start = (state_ff == S_HDR_GO) || (state_ff == S_SUM_GO) ||
                  (state_ff == S_WALK_GO);
      cmd.run   = (state_ff == S_HDR_RUN) || (state_ff == S_SUM_RUN) ||
                  (state_ff == S_WALK_RUN);
      cmd.slide = (state_ff == S_HDR_RUN) && status.done && !status.hdr_ok;
      cmd.emit  = (state_ff == S_EMIT) && status.out_free;
      case (state_ff)
         S_SUM_GO, S_SUM_RUN:   cmd.phase = PH_SUM;
         S_WALK_GO, S_WALK_RUN: cmd.phase = PH_WALK;
         default:               cmd.phase = PH_HDR;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> tb/imu_packet_sync_and_field_extract_test.sv
module imu_packet_sync_and_field_extract_test;
   import ipsfe_pkg::*;

   typedef enum int {
      FK_ZERO,
      FK_FULL,
      FK_MISFIT,
      FK_OVERRUN,
      FK_RANDOM,
      FK_NEAR_MISS
   } frame_kind_type;

   typedef struct {
      frame_kind_type kind;
      logic [7:0]     fill;
      bit             corrupt;
      bit             status_known;
      bit             status;
   } frame_row_type;

   typedef struct {
      bit                 status;
      logic [9:0][31:0]   words;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic        rsp_frame_status;
   logic [31:0] rsp_word [10];

   string word_names [10] = '{
      "accel_x_word", "accel_y_word", "accel_z_word",
      "gyro_x_word", "gyro_y_word", "gyro_z_word",
      "mag_x_word", "mag_y_word", "mag_z_word", "temp_word"
   };

   // predictor state
   logic [7:0]       win [FRAME_LEN];
   int               win_fill;
   logic [9:0][31:0] latest_words;

   logic [7:0]       byte_stream [$];
   frame_result_type frame_results [$];
   bit               known_status [int];
   int               errors = 0;
   int               accepted_bytes = 0;
   int               result_count = 0;
   int               pause_mark = -1;
   int               quiet_cycles = 0;
   int               cycle_count = 0;

   imu_packet_sync_and_field_extract uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_frame_status(rsp_frame_status),
      .rsp_accel_x_word(rsp_word[0]), .rsp_accel_y_word(rsp_word[1]),
      .rsp_accel_z_word(rsp_word[2]), .rsp_gyro_x_word(rsp_word[3]),
      .rsp_gyro_y_word(rsp_word[4]), .rsp_gyro_z_word(rsp_word[5]),
      .rsp_mag_x_word(rsp_word[6]), .rsp_mag_y_word(rsp_word[7]),
      .rsp_mag_z_word(rsp_word[8]), .rsp_temp_word(rsp_word[9])
   );

   always #6 clock = ~clock;

   function automatic logic [31:0] be_word(int at);
      return {win[at], win[at+1], win[at+2], win[at+3]};
   endfunction

   // advance the framer by one received byte
   function automatic void absorb_byte(logic [7:0] b);
      logic [7:0] s1, s2;
      int         i, len;
      bit         bad;
      frame_result_type r;
      s1 = 0;
      s2 = 0;
      if (win_fill >= FRAME_LEN) win_fill = 0;
      win[win_fill] = b;
      win_fill++;
      if (win_fill < FRAME_LEN) return;
      if (!(win[0] == SYNC_BYTE && win[1] == SYNC_BYTE && win[2] == CLASS_BYTE &&
            win[3] == LEN_BYTE)) begin
         for (i = 0; i < FRAME_LEN - 1; i++) win[i] = win[i+1];
         win_fill = FRAME_LEN - 1;
         return;
      end
      for (i = 0; i < FRAME_LEN - 2; i++) begin
         s1 = s1 + win[i];
         s2 = s2 + s1;
      end
      bad = !(s1 == win[FRAME_LEN-2] && s2 == win[FRAME_LEN-1]);
      if (!bad) begin
         i = 4;
         while (i + 1 < FRAME_LEN - 2) begin
            len = win[i+1];
            if (i + 2 + len > FRAME_LEN - 2) break;
            if (len == LEN_VEC3 && (win[i] == ID_ACCEL || win[i] == ID_GYRO ||
                                    win[i] == ID_MAG)) begin
               latest_words[(win[i] - ID_ACCEL) * 3]     = be_word(i + 2);
               latest_words[(win[i] - ID_ACCEL) * 3 + 1] = be_word(i + 6);
               latest_words[(win[i] - ID_ACCEL) * 3 + 2] = be_word(i + 10);
            end else if (win[i] == ID_TEMP && len == LEN_SCALAR) begin
               latest_words[SLOT_TEMP] = be_word(i + 2);
            end
            i = i + 2 + len;
         end
      end
      win_fill = 0;
      r.status = bad;
      r.words = latest_words;
      frame_results.push_back(r);
   endfunction

   // append one record: id, length, data bytes
   function automatic void put_record(ref logic [7:0] f [FRAME_LEN], ref int at,
                                      input logic [7:0] id, input logic [7:0] len,
                                      input logic [7:0] fill, input bit rnd);
      f[at] = id;
      f[at+1] = len;
      for (int k = 0; k < len; k++) f[at+2+k] = rnd ? 8'($urandom) : fill;
      at = at + 2 + len;
   endfunction

   // build a frame and queue its bytes
   function automatic void queue_frame(frame_kind_type kind, logic [7:0] fill, bit corrupt);
      logic [7:0] f [FRAME_LEN];
      logic [7:0] s1, s2, id, len;
      int at, room;
      s1 = 0;
      s2 = 0;
      at = 4;
      for (int k = 0; k < FRAME_LEN; k++) f[k] = 8'($urandom);
      f[0] = SYNC_BYTE;
      f[1] = SYNC_BYTE;
      f[2] = CLASS_BYTE;
      f[3] = LEN_BYTE;
      case (kind)
         FK_ZERO: begin
            for (int k = 4; k < FRAME_LEN - 2; k++) f[k] = 8'h00;
         end
         FK_FULL: begin
            put_record(f, at, ID_ACCEL, LEN_VEC3, fill, 0);
            put_record(f, at, ID_GYRO, LEN_VEC3, fill, 0);
            put_record(f, at, ID_MAG, LEN_VEC3, fill, 0);
            put_record(f, at, ID_TEMP, LEN_SCALAR, fill, 0);
         end
         FK_MISFIT: begin
            put_record(f, at, ID_ACCEL, LEN_SCALAR, fill, 1);
            put_record(f, at, 8'h99, LEN_VEC3, fill, 1);
            put_record(f, at, ID_TEMP, LEN_VEC3, fill, 1);
            put_record(f, at, ID_MAG, 8'h02, fill, 1);
            put_record(f, at, 8'h00, 8'h08, fill, 1);
         end
         FK_OVERRUN: begin
            put_record(f, at, ID_GYRO, LEN_VEC3, fill, 1);
            f[at] = ID_ACCEL;
            f[at+1] = 8'hff;
         end
         default: begin
            // random record layout, mostly well-formed
            while (at + 1 < FRAME_LEN - 2) begin
               room = FRAME_LEN - 2 - at - 2;
               case ($urandom_range(0, 9))
                  0, 1: begin id = ID_ACCEL; len = LEN_VEC3; end
                  2, 3: begin id = ID_GYRO;  len = LEN_VEC3; end
                  4, 5: begin id = ID_MAG;   len = LEN_VEC3; end
                  6, 7: begin id = ID_TEMP;  len = LEN_SCALAR; end
                  8: begin id = 8'($urandom); len = 8'($urandom_range(0, 16)); end
                  default: begin id = 8'($urandom); len = 8'($urandom); end
               endcase
               if (len > room) break;
               put_record(f, at, id, len, fill, 1);
            end
         end
      endcase
      for (int k = 0; k < FRAME_LEN - 2; k++) begin
         s1 = s1 + f[k];
         s2 = s2 + s1;
      end
      f[FRAME_LEN-2] = s1;
      f[FRAME_LEN-1] = s2;
      if (corrupt) begin
         if ($urandom_range(0, 1)) f[FRAME_LEN - 1 - $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
         else f[$urandom_range(4, FRAME_LEN - 3)] ^= 8'h80 >> $urandom_range(0, 7);
      end
      if (kind == FK_NEAR_MISS) begin
         byte_stream.push_back(SYNC_BYTE);
         byte_stream.push_back(SYNC_BYTE);
         byte_stream.push_back(CLASS_BYTE);
         byte_stream.push_back(LEN_BYTE + 8'h01);
      end
      for (int k = 0; k < FRAME_LEN; k++) byte_stream.push_back(f[k]);
   endfunction

   frame_row_type directed_rows [7] = '{
      '{FK_ZERO,      8'h00, 1'b0, 1'b1, 1'b0},
      '{FK_FULL,      8'hff, 1'b0, 1'b1, 1'b0},
      '{FK_FULL,      8'h00, 1'b0, 1'b1, 1'b0},
      '{FK_FULL,      8'h5a, 1'b1, 1'b1, 1'b1},
      '{FK_MISFIT,    8'h00, 1'b0, 1'b1, 1'b0},
      '{FK_OVERRUN,   8'h00, 1'b0, 1'b1, 1'b0},
      '{FK_NEAR_MISS, 8'h00, 1'b0, 1'b0, 1'b0}
   };

   // build the byte stream, run, and report
   initial begin
      for (int k = 0; k < FRAME_LEN; k++) win[k] = 8'h00;
      win_fill = 0;
      latest_words = '0;
      foreach (directed_rows[r]) begin
         queue_frame(directed_rows[r].kind, directed_rows[r].fill, directed_rows[r].corrupt);
         if (directed_rows[r].status_known) known_status[r] = directed_rows[r].status;
      end
      pause_mark = byte_stream.size();
      while (byte_stream.size() < 1450) begin
         case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 20)) byte_stream.push_back(8'($urandom));
            2: queue_frame(FK_RANDOM, 8'h00, 1'b1);
            3: queue_frame(FK_NEAR_MISS, 8'h00, 1'b0);
            default: queue_frame(FK_RANDOM, 8'h00, 1'b0);
         endcase
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (byte_stream.size() == 0 && !req_valid && frame_results.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("imu_packet_sync_and_field_extract_test passed");
      else $display("imu_packet_sync_and_field_extract_test failed");
      $finish;
   end

   // drive bytes, check results, watch for a hang
   always @(posedge clock) begin
      bit calm, hold, got;
      frame_result_type exp_r;
      calm = (cycle_count % 3000) >= 2000;
      got = 1'b0;
      cycle_count++;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            absorb_byte(req_rx_byte);
            void'(byte_stream.pop_front());
            accepted_bytes++;
            got = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            got = 1'b1;
            if (frame_results.size() == 0) begin
               $error("result beat with no frame pending");
               errors++;
            end else begin
               exp_r = frame_results.pop_front();
               if (known_status.exists(result_count) &&
                   known_status[result_count] != rsp_frame_status) begin
                  $error("frame_status: expected %0d, got %0d",
                         known_status[result_count], rsp_frame_status);
                  errors++;
               end
               if (result_count == 0 && rsp_word[0] != 32'h0) begin
                  $error("accel_x_word: expected 0, got %h", rsp_word[0]);
                  errors++;
               end
               if (exp_r.status != rsp_frame_status) begin
                  $error("frame_status: expected %0d, got %0d", exp_r.status, rsp_frame_status);
                  errors++;
               end
               for (int w = 0; w < 10; w++) begin
                  if (exp_r.words[w] != rsp_word[w]) begin
                     $error("%s: expected %h, got %h",
                            word_names[w], exp_r.words[w], rsp_word[w]);
                     errors++;
                  end
               end
            end
            result_count++;
         end
         // hold a stalled beat, otherwise offer the next byte or idle
         hold = (accepted_bytes == pause_mark) && (frame_results.size() != 0);
         if (req_valid && req_stall) begin
         end else if (byte_stream.size() != 0 && !hold &&
                      (calm || $urandom_range(0, 99) >= 27)) begin
            req_valid <= 1'b1;
            req_rx_byte <= byte_stream[0];
         end else begin
            req_valid <= 1'b0;
         end
         rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 27);
         quiet_cycles = got ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= 4000) begin
            $display("imu_packet_sync_and_field_extract_test failed");
            $finish;
         end
      end
   end

endmodule

>>> files.f
rtl/core/ipsfe_pkg.sv
rtl/core/ipsfe_ram.sv
rtl/core/ipsfe_datapath.sv
rtl/core/ipsfe_ctrl.sv
rtl/core/imu_packet_sync_and_field_extract.sv
tb/imu_packet_sync_and_field_extract_test.sv
